[rtl/icm_pkg.sv]
// Shared types and constants for the intervalometer controller.
// Used by icm_step, intervalometer_controller and icm_checker; depends on nothing.
`default_nettype none

package icm_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned CountW  = 16;
  localparam int unsigned TicksW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [TimeW-1:0]  IntervalMsRst   = TimeW'(5000);
  localparam logic [CountW-1:0] ShotCountRst    = CountW'(5);
  localparam logic [TimeW-1:0]  BulbDurationRst = TimeW'(10000);
  localparam logic [CountW-1:0] DebounceMsRst   = CountW'(200);
  localparam logic [CountW-1:0] MinPressMsRst   = CountW'(500);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INTERVAL_MS   = 3'd0,
    CFG_SHOT_COUNT    = 3'd1,
    CFG_BULB_DURATION = 3'd2,
    CFG_MUTE          = 3'd3,
    CFG_BULB_SEL      = 3'd4,
    CFG_DEBOUNCE_MS   = 3'd5,
    CFG_MIN_PRESS_MS  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BEEP_NONE  = 2'd0,
    BEEP_RUN   = 2'd1,
    BEEP_IDLE  = 2'd2,
    BEEP_SHOT  = 2'd3
  } beep_e;

  typedef struct packed {
    logic [TimeW-1:0]  interval_ms;
    logic [CountW-1:0] shot_count;
    logic [TimeW-1:0]  bulb_duration_ms;
    logic              mute;
    logic              bulb_sel;
    logic [CountW-1:0] debounce_ms;
    logic [CountW-1:0] min_press_ms;
  } cfg_t;

  typedef struct packed {
    logic [TicksW-1:0] ticks_elapsed;
    logic              button_held;
    logic              button_pressed;
    logic              fire_request;
  } item_t;

  typedef struct packed {
    logic              running;
    logic [TimeW-1:0]  clock_ms;
    logic [TimeW-1:0]  last_change_time;
    logic [TimeW-1:0]  press_time;
    logic [TimeW-1:0]  last_shot_time;
    logic [TimeW-1:0]  bulb_start_time;
    logic              bulb_done;
    logic              request_pending;
    logic [CountW-1:0] shot_counter;
    logic [TimeW-1:0]  remaining_time;
  } state_t;

  typedef struct packed {
    logic              run_state;
    logic              fire_start;
    logic              fire_long;
    logic              shutter_release;
    logic              shutter_hold;
    beep_e             beep;
    logic [CountW-1:0] shots_taken;
    logic [TimeW-1:0]  time_remaining_ms;
  } result_t;

endpackage

`default_nettype wire

[rtl/intervalometer_controller.sv]
// An accepted input item is registered in item_q; its result is then registered in res_q.
// Throughput: one item per cycle unless out_ready_i stalls; the state update for an item
// completes in the single combinational pass between the item and result registers.
// Reset (rst_ni low, async): idle, clock and all times zero, config to defaults, no valid.
// Depends on icm_pkg and icm_step.
`default_nettype none

module intervalometer_controller (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [icm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [icm_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [icm_pkg::TicksW-1:0]    ticks_elapsed_i,
  input  wire logic                          button_held_i,
  input  wire logic                          button_pressed_i,
  input  wire logic                          fire_request_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               run_state_o,
  output logic                               fire_start_o,
  output logic                               fire_long_o,
  output logic                               shutter_release_o,
  output logic                               shutter_hold_o,
  output logic [1:0]                         beep_o,
  output logic [icm_pkg::CountW-1:0]         shots_taken_o,
  output logic [icm_pkg::TimeW-1:0]          time_remaining_ms_o
);

  icm_pkg::cfg_t    cfg_q;
  icm_pkg::item_t   item_q;
  logic             item_valid_q;
  icm_pkg::state_t  state_q, state_d;
  icm_pkg::result_t res_q, res_d;
  logic             out_valid_q;
  logic             advance;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.interval_ms      <= icm_pkg::IntervalMsRst;
      cfg_q.shot_count       <= icm_pkg::ShotCountRst;
      cfg_q.bulb_duration_ms <= icm_pkg::BulbDurationRst;
      cfg_q.mute             <= 1'b0;
      cfg_q.bulb_sel         <= 1'b0;
      cfg_q.debounce_ms      <= icm_pkg::DebounceMsRst;
      cfg_q.min_press_ms     <= icm_pkg::MinPressMsRst;
    end else if (cfg_we_i) begin
      unique case (icm_pkg::cfg_idx_e'(cfg_index_i))
        icm_pkg::CFG_INTERVAL_MS:   cfg_q.interval_ms      <= cfg_data_i;
        icm_pkg::CFG_SHOT_COUNT:    cfg_q.shot_count       <= cfg_data_i[icm_pkg::CountW-1:0];
        icm_pkg::CFG_BULB_DURATION: cfg_q.bulb_duration_ms <= cfg_data_i;
        icm_pkg::CFG_MUTE:          cfg_q.mute             <= cfg_data_i[0];
        icm_pkg::CFG_BULB_SEL:      cfg_q.bulb_sel         <= cfg_data_i[0];
        icm_pkg::CFG_DEBOUNCE_MS:   cfg_q.debounce_ms      <= cfg_data_i[icm_pkg::CountW-1:0];
        icm_pkg::CFG_MIN_PRESS_MS:  cfg_q.min_press_ms     <= cfg_data_i[icm_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // item moves to the result register when that register is free or being drained
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.ticks_elapsed  <= ticks_elapsed_i;
      item_q.button_held    <= button_held_i;
      item_q.button_pressed <= button_pressed_i;
      item_q.fire_request   <= fire_request_i;
    end
  end

  icm_step u_step (
    .cfg_i   (cfg_q),
    .item_i  (item_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (item_valid_q && advance) begin
      state_q     <= state_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid_q && advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign run_state_o         = res_q.run_state;
  assign fire_start_o        = res_q.fire_start;
  assign fire_long_o         = res_q.fire_long;
  assign shutter_release_o   = res_q.shutter_release;
  assign shutter_hold_o      = res_q.shutter_hold;
  assign beep_o              = res_q.beep;
  assign shots_taken_o       = res_q.shots_taken;
  assign time_remaining_ms_o = res_q.time_remaining_ms;

endmodule

`default_nettype wire

[rtl/icm_step.sv]
// One main-loop pass: update rule then action rule, purely combinational.
// Depends on icm_pkg for the config, item, state and result structs.
`default_nettype none

module icm_step (
  input  wire icm_pkg::cfg_t    cfg_i,
  input  wire icm_pkg::item_t   item_i,
  input  wire icm_pkg::state_t  state_i,
  output icm_pkg::state_t       state_o,
  output icm_pkg::result_t      res_o
);

  always_comb begin
    icm_pkg::state_t        s;
    icm_pkg::beep_e         bp;
    logic                   fs;
    logic                   fl;
    logic                   rel;
    logic                   hold;
    logic                   toggle;
    logic                   long_press;
    logic [icm_pkg::TimeW-1:0] el;

    s    = state_i;
    bp   = icm_pkg::BEEP_NONE;
    fs   = 1'b0;
    fl   = 1'b0;
    rel  = 1'b0;
    hold = 1'b0;
    el   = '0;

    if (item_i.button_pressed) begin
      s.press_time = s.clock_ms;
    end
    if (item_i.fire_request) begin
      s.request_pending = 1'b1;
    end
    s.clock_ms = s.clock_ms + icm_pkg::TimeW'(item_i.ticks_elapsed);

    toggle = item_i.button_held &&
             ((s.clock_ms - s.last_change_time) > icm_pkg::TimeW'(cfg_i.debounce_ms));
    long_press = (s.clock_ms - s.press_time) >= icm_pkg::TimeW'(cfg_i.min_press_ms);

    // update rule
    if (!s.running) begin
      if (toggle) begin
        if (long_press) begin
          s.last_shot_time   = s.clock_ms;
          s.last_change_time = s.clock_ms;
          s.press_time       = s.clock_ms;
          bp                 = icm_pkg::BEEP_RUN;
          s.running          = 1'b1;
        end
      end else begin
        s.last_shot_time = s.clock_ms;
      end
    end else begin
      if (toggle && long_press) begin
        s.last_shot_time   = s.clock_ms;
        s.last_change_time = s.clock_ms;
        s.press_time       = s.clock_ms;
        s.shot_counter     = '0;
        if (cfg_i.bulb_sel) begin
          rel = 1'b1;
        end
        bp        = icm_pkg::BEEP_IDLE;
        s.running = 1'b0;
      end
      if (!cfg_i.bulb_sel) begin
        if ((s.clock_ms - s.last_shot_time) >= cfg_i.interval_ms) begin
          s.last_shot_time  = s.clock_ms;
          s.request_pending = 1'b1;
        end
        if (s.shot_counter >= cfg_i.shot_count) begin
          s.request_pending = 1'b0;
          s.shot_counter    = '0;
          bp                = icm_pkg::BEEP_IDLE;
          s.running         = 1'b0;
        end
      end else if (!s.bulb_done) begin
        // bulb exposure not started yet: stays running
        s.running         = 1'b1;
        s.request_pending = 1'b1;
      end
    end

    // action rule
    if (!s.running) begin
      if (s.request_pending) begin
        s.request_pending = 1'b0;
        if (!cfg_i.bulb_sel) begin
          bp = icm_pkg::BEEP_SHOT;
          fs = 1'b1;
        end else begin
          s.bulb_start_time = s.clock_ms;
          hold              = 1'b1;
        end
      end
    end else if (!cfg_i.bulb_sel) begin
      if (s.request_pending) begin
        s.request_pending = 1'b0;
        bp                = icm_pkg::BEEP_SHOT;
        fs                = 1'b1;
        s.shot_counter    = s.shot_counter + icm_pkg::CountW'(1);
      end
      el = s.clock_ms - s.last_shot_time;
      s.remaining_time = (cfg_i.interval_ms > el) ? (cfg_i.interval_ms - el) : '0;
    end else begin
      if (!s.bulb_done) begin
        s.request_pending = 1'b0;
        fs                = 1'b1;
        fl                = 1'b1;
        s.bulb_start_time = s.clock_ms;
        s.bulb_done       = 1'b1;
      end
      el = s.clock_ms - s.bulb_start_time;
      // saturate at zero rather than wrap
      s.remaining_time = (cfg_i.bulb_duration_ms > el) ? (cfg_i.bulb_duration_ms - el) : '0;
      if (el > cfg_i.bulb_duration_ms) begin
        s.bulb_done = 1'b0;
        rel         = 1'b1;
        bp          = icm_pkg::BEEP_IDLE;
        s.running   = 1'b0;
      end
    end

    state_o                 = s;
    res_o.run_state         = s.running;
    res_o.fire_start        = fs;
    res_o.fire_long         = fl;
    res_o.shutter_release   = rel;
    res_o.shutter_hold      = hold;
    res_o.beep              = cfg_i.mute ? icm_pkg::BEEP_NONE : bp;
    res_o.shots_taken       = s.shot_counter;
    res_o.time_remaining_ms = s.remaining_time;
  end

endmodule

`default_nettype wire

[rtl/icm_checker.sv]
// Port-level checks for intervalometer_controller, bound to the top level.
// Depends on icm_pkg for field widths.
`default_nettype none

module icm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_ready_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire logic                          run_state_o,
  input wire logic                          fire_start_o,
  input wire logic                          fire_long_o,
  input wire logic                          shutter_hold_o,
  input wire logic [1:0]                    beep_o,
  input wire logic [icm_pkg::CountW-1:0]    shots_taken_o,
  input wire logic [icm_pkg::TimeW-1:0]     time_remaining_ms_o
);

  // a bulb press is always a started press and leaves the block running
  a_long_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fire_long_o |-> fire_start_o && run_state_o)
    else $error("fire_long without fire_start or while idle");

  // shutter hold only comes from the idle path and never with a press start
  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && shutter_hold_o |-> !run_state_o && !fire_start_o)
    else $error("shutter_hold while running or with fire_start");

  // input side only backs up while a result waits
  a_ready_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(beep_o) &&
      $stable(shots_taken_o) && $stable(time_remaining_ms_o))
    else $error("stalled result changed");

endmodule

bind intervalometer_controller icm_checker u_icm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready_o          (in_ready_o),
  .out_valid_o         (out_valid_o),
  .out_ready_i         (out_ready_i),
  .run_state_o         (run_state_o),
  .fire_start_o        (fire_start_o),
  .fire_long_o         (fire_long_o),
  .shutter_hold_o      (shutter_hold_o),
  .beep_o              (beep_o),
  .shots_taken_o       (shots_taken_o),
  .time_remaining_ms_o (time_remaining_ms_o)
);

`default_nettype wire
